### rtl/kmt_pkg.sv
package kmt_pkg;

  // Event codes carried on the result channel.
  localparam logic [2:0] EV_UP     = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_SELECT = 3'd2;
  localparam logic [2:0] EV_BACK   = 3'd3;
  localparam logic [2:0] EV_LEFT   = 3'd4;
  localparam logic [2:0] EV_RIGHT  = 3'd5;
  localparam logic [2:0] EV_CHAR   = 3'd6;

  localparam logic [15:0] TAP_TIMEOUT_RESET = 16'd900;

  // Role of one keypad switch: a navigation event or a digit key.
  typedef struct packed {
    logic       is_digit;
    logic [3:0] value;
  } key_role_t;

  // One result word.
  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] char_code;
    logic       last_event;
  } result_t;

  // Up to two result words caused by one scan.
  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] count;
  } result_pair_t;

  // Fixed keypad layout, indexed by row*4+col.
  function automatic key_role_t key_role(input logic [3:0] idx);
    key_role_t r;
    r = '0;
    unique case (idx)
      4'd0:  r = '{1'b0, {1'b0, EV_BACK}};
      4'd1:  r = '{1'b0, {1'b0, EV_RIGHT}};
      4'd2:  r = '{1'b1, 4'd0};
      4'd3:  r = '{1'b0, {1'b0, EV_LEFT}};
      4'd4:  r = '{1'b0, {1'b0, EV_SELECT}};
      4'd5:  r = '{1'b1, 4'd9};
      4'd6:  r = '{1'b1, 4'd8};
      4'd7:  r = '{1'b1, 4'd7};
      4'd8:  r = '{1'b0, {1'b0, EV_DOWN}};
      4'd9:  r = '{1'b1, 4'd6};
      4'd10: r = '{1'b1, 4'd5};
      4'd11: r = '{1'b1, 4'd4};
      4'd12: r = '{1'b0, {1'b0, EV_UP}};
      4'd13: r = '{1'b1, 4'd3};
      4'd14: r = '{1'b1, 4'd2};
      4'd15: r = '{1'b1, 4'd1};
    endcase
    return r;
  endfunction

  // Number of characters in each digit's cycle.
  function automatic logic [2:0] cycle_len(input logic [3:0] digit);
    logic [2:0] n;
    case (digit)
      4'd0:                n = 3'd2;
      4'd1, 4'd7, 4'd9:    n = 3'd5;
      default:             n = 3'd4;
    endcase
    return n;
  endfunction

  // Character at a position of a digit's cycle; the first character sits in the top byte.
  function automatic logic [7:0] cycle_char(input logic [3:0] digit, input logic [2:0] pos);
    logic [39:0] str;
    logic [39:0] sh;
    case (digit)
      4'd0:    str = {" 0", 24'h0};
      4'd1:    str = "1.,?!";
      4'd2:    str = {"abc2", 8'h0};
      4'd3:    str = {"def3", 8'h0};
      4'd4:    str = {"ghi4", 8'h0};
      4'd5:    str = {"jkl5", 8'h0};
      4'd6:    str = {"mno6", 8'h0};
      4'd7:    str = "pqrs7";
      4'd8:    str = {"tuv8", 8'h0};
      4'd9:    str = "wxyz9";
      default: str = '0;
    endcase
    sh = str << {pos, 3'b000};
    return sh[39:32];
  endfunction

endpackage

### rtl/keypad_multitap_text_entry_unit.sv
// Channel | Handshake             | Word
// in_     | in_valid / in_stall   | pressed_keys, now_ms (one keypad scan)
// out_    | out_valid / out_stall | event_code, char_code, last_event
// cfg_    | cfg_valid / cfg_ready | tap_timeout_ms (always ready)
//
// A scan is registered, decoded combinationally and moved into a two-entry result
// register; results then leave one word per cycle while out_stall is low, and a
// repeat tap (back then character) yields two words.
// Reset is synchronous and active low; it clears the tap state and sets the
// timeout to 900 ms. Input stall is high while a scan waits and the result register
// holds words that will not all leave this cycle (a second word, or out_stall).
module keypad_multitap_text_entry_unit #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pressed_keys,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_code,
  output logic [7:0]  out_char_code,
  output logic        out_last_event,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_tap_timeout_ms
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [15:0]           pressed_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [15:0]           timeout_r;

  kmt_pkg::result_pair_t pair;
  kmt_pkg::result_t      res0_r, res1_r;
  logic [1:0]            cnt_r, cnt_nxt;

  logic in_acc, out_acc, load_ok, s1_adv;

  // Handshake decisions.
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_acc);
  assign s1_adv    = s1_valid_r && load_ok;
  assign in_stall  = s1_valid_r && !load_ok;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= kmt_pkg::TAP_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_tap_timeout_ms;
    end
  end

  // Input register.
  assign s1_valid_nxt = in_acc || in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pressed_r <= in_pressed_keys;
      now_r     <= in_now_ms[TIME_WIDTH-1:0];
    end
  end

  kmt_tap_logic #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_tap (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_adv),
    .pressed_keys   (pressed_r),
    .now_ms         (now_r),
    .tap_timeout_ms (timeout_r),
    .pair           (pair)
  );

  // Result register: holds up to two words and drains one per cycle while out_stall is low.
  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_adv) begin
      cnt_nxt = pair.count;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res0_r <= pair.res0;
      res1_r <= pair.res1;
    end else if (out_acc) begin
      res0_r <= res1_r;
    end
  end

  assign out_event_code = res0_r.event_code;
  assign out_char_code  = res0_r.char_code;
  assign out_last_event = res0_r.last_event;

endmodule

### rtl/kmt_tap_logic.sv
module kmt_tap_logic #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [15:0]             pressed_keys,
  input  logic [TIME_WIDTH-1:0]   now_ms,
  input  logic [15:0]             tap_timeout_ms,
  output kmt_pkg::result_pair_t   pair
);

  logic [4:0]            previous_key_r, previous_key_nxt;
  logic [4:0]            last_tap_key_r, last_tap_key_nxt;
  logic [2:0]            tap_position_r, tap_position_nxt;
  logic [TIME_WIDTH-1:0] last_tap_time_r, last_tap_time_nxt;

  logic [3:0]            key_idx;
  logic                  key_any;
  logic [4:0]            key;
  kmt_pkg::key_role_t    role;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  repeat_tap;
  logic [2:0]            pos_inc;
  logic [2:0]            pos_new;
  logic [7:0]            ch;

  // The highest pressed switch wins.
  always_comb begin
    key_idx = '0;
    key_any = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (pressed_keys[i]) begin
        key_idx = 4'(i);
        key_any = 1'b1;
      end
    end
  end

  assign key = key_any ? ({1'b0, key_idx} + 5'd1) : 5'd0;
  assign role = kmt_pkg::key_role(key_idx);

  // Repeat detection over the wrapping millisecond clock.
  assign elapsed    = now_ms - last_tap_time_r;
  assign repeat_tap = (key == last_tap_key_r) &&
                      (elapsed < {{(TIME_WIDTH-16){1'b0}}, tap_timeout_ms});
  assign pos_inc    = tap_position_r + 3'd1;

  always_comb begin
    pos_new = repeat_tap ? pos_inc : 3'd0;
    if (pos_new >= kmt_pkg::cycle_len(role.value)) begin
      pos_new = 3'd0;
    end
  end

  assign ch = kmt_pkg::cycle_char(role.value, pos_new);

  // Results and next state for the scan at the input.
  always_comb begin
    pair              = '0;
    previous_key_nxt  = previous_key_r;
    last_tap_key_nxt  = last_tap_key_r;
    tap_position_nxt  = tap_position_r;
    last_tap_time_nxt = last_tap_time_r;
    if (key != previous_key_r) begin
      previous_key_nxt = key;
      if (key_any) begin
        if (!role.is_digit) begin
          last_tap_key_nxt = 5'd0;
          pair.count       = 2'd1;
          pair.res0        = '{role.value[2:0], 8'h00, 1'b1};
        end else begin
          last_tap_key_nxt  = key;
          last_tap_time_nxt = now_ms;
          tap_position_nxt  = pos_new;
          if (repeat_tap) begin
            pair.count = 2'd2;
            pair.res0  = '{kmt_pkg::EV_BACK, 8'h00, 1'b0};
            pair.res1  = '{kmt_pkg::EV_CHAR, ch, 1'b1};
          end else begin
            pair.count = 2'd1;
            pair.res0  = '{kmt_pkg::EV_CHAR, ch, 1'b1};
          end
        end
      end
    end
  end

  // Tap state advances only when the scan moves on to the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_key_r  <= '0;
      last_tap_key_r  <= '0;
      tap_position_r  <= '0;
      last_tap_time_r <= '0;
    end else if (step) begin
      previous_key_r  <= previous_key_nxt;
      last_tap_key_r  <= last_tap_key_nxt;
      tap_position_r  <= tap_position_nxt;
      last_tap_time_r <= last_tap_time_nxt;
    end
  end

endmodule
